[hdl/fstp_pkg.sv]
// ----------------------------------------------------------------------------
// fstp_pkg
// Shared types and constants of the framed serial target parser.
// ----------------------------------------------------------------------------
`default_nettype none

package fstp_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 32;
    localparam int unsigned LEN_W           = 6;
    localparam int unsigned HEAD_DEPTH      = 7;
    localparam int unsigned HEAD_IDX_W      = 3;

    localparam logic [7:0] SYNC1_BYTE  = 8'hAA;
    localparam logic [7:0] SYNC2_BYTE  = 8'h55;
    localparam logic [7:0] CR_BYTE     = 8'h0D;
    localparam logic [7:0] LF_BYTE     = 8'h0A;
    localparam logic [7:0] TYPE_TARGET = 8'h01;
    localparam logic [7:0] TYPE_CMD    = 8'h02;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_TARGET  = 2'd1,
        EV_COMMAND = 2'd2
    } t_event;

    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_LEN   = 3'd2,
        PH_TYPE  = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHK   = 3'd5,
        PH_CR    = 3'd6,
        PH_LF    = 3'd7
    } t_phase;

    typedef struct packed {
        logic                               done;
        logic [7:0]                         kind;
        logic [LEN_W-1:0]                   length;
        logic [HEAD_DEPTH-1:0][7:0]         head;
    } t_frame_info;

endpackage

`default_nettype wire

[hdl/fstp_in_if.sv]
// ----------------------------------------------------------------------------
// fstp_in_if
// Request channel carrying one received byte and its timestamp.
// ----------------------------------------------------------------------------
`default_nettype none

interface fstp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;
    logic [31:0] time_ms;

    modport source (output valid, output rx_byte, output time_ms, input ready);
    modport sink   (input valid, input rx_byte, input time_ms, output ready);
endinterface

`default_nettype wire

[hdl/fstp_out_if.sv]
// ----------------------------------------------------------------------------
// fstp_out_if
// Result channel carrying one parse result per received byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface fstp_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         event_kind;
    logic [7:0]         frame_kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         obj_class;
    logic [15:0]        area;
    logic [31:0]        stamp_ms;
    logic [7:0]         command_code;

    modport source (output valid, output event_kind, output frame_kind, output pos_x,
                    output pos_y, output obj_class, output area, output stamp_ms,
                    output command_code, input ready);
    modport sink   (input valid, input event_kind, input frame_kind, input pos_x,
                    input pos_y, input obj_class, input area, input stamp_ms,
                    input command_code, output ready);
endinterface

`default_nettype wire

[hdl/fstp_frame_fsm.sv]
// ----------------------------------------------------------------------------
// fstp_frame_fsm
// Frame parser state: sync hunt, length/type capture, payload head and XOR.
// ----------------------------------------------------------------------------
`default_nettype none

module fstp_frame_fsm #(
    parameter int unsigned P_MAX_PAYLOAD = fstp_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire logic [7:0]            i_byte,
    output fstp_pkg::t_frame_info      o_info
);

    localparam logic [7:0] MAX_LEN = 8'(P_MAX_PAYLOAD);

    fstp_pkg::t_phase                r_phase, n_phase;
    logic [fstp_pkg::LEN_W-1:0]      r_length, n_length;
    logic [7:0]                      r_type, n_type;
    logic [fstp_pkg::LEN_W-1:0]      r_index, n_index;
    logic [7:0]                      r_xor, n_xor;
    logic [7:0]                      r_head [fstp_pkg::HEAD_DEPTH];
    logic                            head_we;
    logic                            lf_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= fstp_pkg::PH_SYNC1;
            r_length <= '0;
            r_type   <= '0;
            r_index  <= '0;
            r_xor    <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_length <= n_length;
            r_type   <= n_type;
            r_index  <= n_index;
            r_xor    <= n_xor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && head_we) begin
            r_head[r_index[fstp_pkg::HEAD_IDX_W-1:0]] <= i_byte;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_length = r_length;
        n_type   = r_type;
        n_index  = r_index;
        n_xor    = r_xor;
        head_we  = 1'b0;
        lf_hit   = 1'b0;
        case (r_phase)
            fstp_pkg::PH_SYNC1: begin
                if (i_byte == fstp_pkg::SYNC1_BYTE) n_phase = fstp_pkg::PH_SYNC2;
            end
            fstp_pkg::PH_SYNC2: begin
                n_phase = (i_byte == fstp_pkg::SYNC2_BYTE) ? fstp_pkg::PH_LEN
                                                           : fstp_pkg::PH_SYNC1;
            end
            fstp_pkg::PH_LEN: begin
                if (i_byte == 8'd0 || i_byte > MAX_LEN) begin
                    n_phase = fstp_pkg::PH_SYNC1;
                end else begin
                    n_length = i_byte[fstp_pkg::LEN_W-1:0];
                    n_xor    = i_byte;
                    n_phase  = fstp_pkg::PH_TYPE;
                end
            end
            fstp_pkg::PH_TYPE: begin
                n_type  = i_byte;
                n_xor   = r_xor ^ i_byte;
                n_index = '0;
                n_phase = fstp_pkg::PH_DATA;
            end
            fstp_pkg::PH_DATA: begin
                if (r_index < r_length) begin
                    head_we = (r_index < fstp_pkg::LEN_W'(fstp_pkg::HEAD_DEPTH));
                    n_index = r_index + fstp_pkg::LEN_W'(1);
                    n_xor   = r_xor ^ i_byte;
                end
                if (n_index >= r_length) n_phase = fstp_pkg::PH_CHK;
            end
            fstp_pkg::PH_CHK: begin
                n_phase = (i_byte == r_xor) ? fstp_pkg::PH_CR : fstp_pkg::PH_SYNC1;
            end
            fstp_pkg::PH_CR: begin
                n_phase = (i_byte == fstp_pkg::CR_BYTE) ? fstp_pkg::PH_LF
                                                        : fstp_pkg::PH_SYNC1;
            end
            default: begin
                n_phase = fstp_pkg::PH_SYNC1;
                lf_hit  = (i_byte == fstp_pkg::LF_BYTE);
            end
        endcase
    end

    always_comb begin
        o_info.done   = lf_hit;
        o_info.kind   = r_type;
        o_info.length = r_length;
        for (int k = 0; k < fstp_pkg::HEAD_DEPTH; k++) begin
            o_info.head[k] = r_head[k];
        end
    end

endmodule

`default_nettype wire

[hdl/framed_serial_target_parser_core.sv]
// ----------------------------------------------------------------------------
// framed_serial_target_parser_core
// Parses AA 55 LEN TYPE payload CHK CR LF frames from a byte stream.
// ----------------------------------------------------------------------------
// Every accepted byte yields exactly one result in the following cycle, from a
// single registered stage: the parser state and the result register update
// on the same edge. A new byte is taken every cycle while the result register
// is empty or being drained, so throughput is one byte per clock. A result of
// kind target (type 1, at least 7 payload bytes) or command (type 2) appears
// on the LF byte of a frame whose checksum, CR and LF checked good; all other
// bytes give a none result with all fields zero.
`default_nettype none

module framed_serial_target_parser_core #(
    parameter int unsigned P_MAX_PAYLOAD = fstp_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    fstp_in_if.sink        i_in,
    fstp_out_if.source     o_out
);

    fstp_pkg::t_frame_info frame_info;
    logic                  step;

    logic                  r_valid;
    logic [1:0]            r_event, n_event;
    logic [7:0]            r_kind, n_kind;
    logic [15:0]           r_x, n_x;
    logic [15:0]           r_y, n_y;
    logic [7:0]            r_class, n_class;
    logic [15:0]           r_area, n_area;
    logic [31:0]           r_stamp, n_stamp;
    logic [7:0]            r_cmd, n_cmd;

    assign i_in.ready = !r_valid || o_out.ready;
    assign step       = i_in.valid && i_in.ready;

    fstp_frame_fsm #(
        .P_MAX_PAYLOAD (P_MAX_PAYLOAD)
    ) u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (i_in.rx_byte),
        .o_info  (frame_info)
    );

    always_comb begin
        n_event = fstp_pkg::EV_NONE;
        n_kind  = '0;
        n_x     = '0;
        n_y     = '0;
        n_class = '0;
        n_area  = '0;
        n_stamp = '0;
        n_cmd   = '0;
        if (frame_info.done) begin
            if (frame_info.kind == fstp_pkg::TYPE_TARGET &&
                frame_info.length >= fstp_pkg::LEN_W'(fstp_pkg::HEAD_DEPTH)) begin
                n_event = fstp_pkg::EV_TARGET;
                n_kind  = frame_info.kind;
                n_x     = {frame_info.head[1], frame_info.head[0]};
                n_y     = {frame_info.head[3], frame_info.head[2]};
                n_class = frame_info.head[4];
                n_area  = {frame_info.head[6], frame_info.head[5]};
                n_stamp = i_in.time_ms;
            end else if (frame_info.kind == fstp_pkg::TYPE_CMD &&
                         frame_info.length != '0) begin
                n_event = fstp_pkg::EV_COMMAND;
                n_kind  = frame_info.kind;
                n_cmd   = frame_info.head[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (step) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_event <= n_event;
            r_kind  <= n_kind;
            r_x     <= n_x;
            r_y     <= n_y;
            r_class <= n_class;
            r_area  <= n_area;
            r_stamp <= n_stamp;
            r_cmd   <= n_cmd;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.event_kind   = r_event;
    assign o_out.frame_kind   = r_kind;
    assign o_out.pos_x        = r_x;
    assign o_out.pos_y        = r_y;
    assign o_out.obj_class    = r_class;
    assign o_out.area         = r_area;
    assign o_out.stamp_ms     = r_stamp;
    assign o_out.command_code = r_cmd;

endmodule

`default_nettype wire

[hdl/fstp_checker.sv]
// ----------------------------------------------------------------------------
// fstp_checker
// Port-level checks of the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fstp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  i_event_kind,
    input wire logic [7:0]  i_frame_kind,
    input wire logic [7:0]  i_command_code,
    input wire logic [31:0] i_stamp_ms
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_event_kind)
                                        && $stable(i_frame_kind))
        else $error("stalled result changed");

    // every accepted request produces a result next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("request without result");

    // no new request while a result is stuck
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("request taken over a stalled result");

    // frame kind follows the event kind
    a_kind_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_event_kind == fstp_pkg::EV_NONE && i_frame_kind == 8'd0
                            && i_command_code == 8'd0 && i_stamp_ms == 32'd0)
                     || (i_event_kind == fstp_pkg::EV_TARGET
                            && i_frame_kind == fstp_pkg::TYPE_TARGET
                            && i_command_code == 8'd0)
                     || (i_event_kind == fstp_pkg::EV_COMMAND
                            && i_frame_kind == fstp_pkg::TYPE_CMD
                            && i_stamp_ms == 32'd0))
        else $error("inconsistent result fields");

endmodule

bind framed_serial_target_parser_core fstp_checker u_fstp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_event_kind   (o_out.event_kind),
    .i_frame_kind   (o_out.frame_kind),
    .i_command_code (o_out.command_code),
    .i_stamp_ms     (o_out.stamp_ms)
);

`default_nettype wire

[tb/fstp_result_checker.sv]
// ----------------------------------------------------------------------------
// fstp_result_checker
// Watches the request and result channels of the frame parser, tracks the
// parse state of every accepted byte and compares each result field by field
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module fstp_result_checker #(
    parameter int unsigned P_MAX_PAYLOAD = fstp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    fstp_in_if   i_req,
    fstp_out_if  i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_targets,
    output int   o_commands
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_LIMIT = 50;

    typedef struct packed {
        fstp_pkg::t_event   ev;
        logic [7:0]         kind;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [7:0]         cls;
        logic [15:0]        area;
        logic [31:0]        stamp;
        logic [7:0]         cmd;
    } t_parse_result;

    fstp_pkg::t_phase phase;
    logic [5:0]       frame_len;
    logic [7:0]       cur_type;
    logic [5:0]       data_idx;
    logic [7:0]       running_xor;
    logic [7:0]       head_bytes [fstp_pkg::HEAD_DEPTH];

    t_parse_result awaited_results [$];
    t_parse_result seen;
    t_parse_result want;

    function automatic t_parse_result parse_rx_byte(input logic [7:0] b, input logic [31:0] t);
        t_parse_result r;
        r = '0;
        case (phase)
            fstp_pkg::PH_SYNC1: begin
                if (b == fstp_pkg::SYNC1_BYTE) phase = fstp_pkg::PH_SYNC2;
            end
            fstp_pkg::PH_SYNC2: begin
                phase = (b == fstp_pkg::SYNC2_BYTE) ? fstp_pkg::PH_LEN : fstp_pkg::PH_SYNC1;
            end
            fstp_pkg::PH_LEN: begin
                if (b == 8'd0 || b > P_MAX_PAYLOAD) begin
                    phase = fstp_pkg::PH_SYNC1;
                end else begin
                    frame_len   = b[5:0];
                    running_xor = b;
                    phase       = fstp_pkg::PH_TYPE;
                end
            end
            fstp_pkg::PH_TYPE: begin
                cur_type    = b;
                running_xor = running_xor ^ b;
                data_idx    = '0;
                phase       = fstp_pkg::PH_DATA;
            end
            fstp_pkg::PH_DATA: begin
                if (data_idx < frame_len) begin
                    if (data_idx < fstp_pkg::HEAD_DEPTH) head_bytes[data_idx[2:0]] = b;
                    data_idx    = data_idx + 6'd1;
                    running_xor = running_xor ^ b;
                end
                if (data_idx >= frame_len) phase = fstp_pkg::PH_CHK;
            end
            fstp_pkg::PH_CHK: begin
                phase = (b == running_xor) ? fstp_pkg::PH_CR : fstp_pkg::PH_SYNC1;
            end
            fstp_pkg::PH_CR: begin
                phase = (b == fstp_pkg::CR_BYTE) ? fstp_pkg::PH_LF : fstp_pkg::PH_SYNC1;
            end
            default: begin
                phase = fstp_pkg::PH_SYNC1;
                if (b == fstp_pkg::LF_BYTE) begin
                    if (cur_type == fstp_pkg::TYPE_TARGET &&
                        frame_len >= fstp_pkg::HEAD_DEPTH) begin
                        r.ev    = fstp_pkg::EV_TARGET;
                        r.kind  = cur_type;
                        r.cx    = {head_bytes[1], head_bytes[0]};
                        r.cy    = {head_bytes[3], head_bytes[2]};
                        r.cls   = head_bytes[4];
                        r.area  = {head_bytes[6], head_bytes[5]};
                        r.stamp = t;
                    end else if (cur_type == fstp_pkg::TYPE_CMD && frame_len >= 6'd1) begin
                        r.ev   = fstp_pkg::EV_COMMAND;
                        r.kind = cur_type;
                        r.cmd  = head_bytes[0];
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        o_fail_count++;
        if (o_fail_count <= PRINT_LIMIT) begin
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                     $time, field, got, exp_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase       = fstp_pkg::PH_SYNC1;
            frame_len   = '0;
            cur_type    = '0;
            data_idx    = '0;
            running_xor = '0;
            foreach (head_bytes[k]) head_bytes[k] = '0;
            awaited_results.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                seen.ev    = fstp_pkg::t_event'(i_res.event_kind);
                seen.kind  = i_res.frame_kind;
                seen.cx    = i_res.pos_x;
                seen.cy    = i_res.pos_y;
                seen.cls   = i_res.obj_class;
                seen.area  = i_res.area;
                seen.stamp = i_res.stamp_ms;
                seen.cmd   = i_res.command_code;
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with no request outstanding", 32'(seen.ev), '0);
                end else begin
                    want = awaited_results.pop_front();
                    if (seen.ev !== want.ev)
                        report_mismatch("event_kind", 32'(seen.ev), 32'(want.ev));
                    if (seen.kind !== want.kind)
                        report_mismatch("frame_kind", 32'(seen.kind), 32'(want.kind));
                    if (seen.cx !== want.cx)
                        report_mismatch("pos_x", 32'(seen.cx), 32'(want.cx));
                    if (seen.cy !== want.cy)
                        report_mismatch("pos_y", 32'(seen.cy), 32'(want.cy));
                    if (seen.cls !== want.cls)
                        report_mismatch("obj_class", 32'(seen.cls), 32'(want.cls));
                    if (seen.area !== want.area)
                        report_mismatch("area", 32'(seen.area), 32'(want.area));
                    if (seen.stamp !== want.stamp)
                        report_mismatch("stamp_ms", seen.stamp, want.stamp);
                    if (seen.cmd !== want.cmd)
                        report_mismatch("command_code", 32'(seen.cmd), 32'(want.cmd));
                    if (want.ev == fstp_pkg::EV_TARGET) o_targets++;
                    if (want.ev == fstp_pkg::EV_COMMAND) o_commands++;
                end
            end
            if (i_req.valid && i_req.ready) begin
                awaited_results.push_back(parse_rx_byte(i_req.rx_byte, i_req.time_ms));
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

[tb/tb_framed_serial_target_parser_core.sv]
// ----------------------------------------------------------------------------
// tb_framed_serial_target_parser_core
// Drives byte streams into the frame parser: directed frames at the field
// extremes and every error path, then random good, broken and noise traffic
// under three flow-control profiles. Checking lives in fstp_result_checker.
// ----------------------------------------------------------------------------
module tb_framed_serial_target_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_LEN        = fstp_pkg::MAX_PAYLOAD_DEF;
    localparam int          N_ITEMS        = 1550;
    localparam int          WATCHDOG_LIMIT = 4000;

    typedef enum int {
        FLAW_NONE,
        FLAW_SYNC2,
        FLAW_LEN,
        FLAW_CHK,
        FLAW_CR,
        FLAW_LF,
        FLAW_CUT
    } t_flaw;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int          snd_idle_pct;
    int          rcv_idle_pct;
    int          bytes_sent;
    int          frames_sent;
    int          idle_cycles;
    logic [31:0] ms_now;
    int          fail_count;
    int          pending;
    int          n_targets;
    int          n_commands;

    fstp_in_if  req_if ();
    fstp_out_if res_if ();

    framed_serial_target_parser_core #(
        .P_MAX_PAYLOAD (MAX_LEN)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    fstp_result_checker #(
        .P_MAX_PAYLOAD (MAX_LEN)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_targets    (n_targets),
        .o_commands   (n_commands)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    function automatic logic [31:0] next_ms();
        if ($urandom_range(0, 31) == 0) ms_now = $urandom();
        else ms_now = ms_now + $urandom_range(0, 3);
        return ms_now;
    endfunction

    function automatic int pick_len(input logic [7:0] ftype);
        int r;
        r = $urandom_range(0, 99);
        if (ftype == fstp_pkg::TYPE_TARGET) begin
            if (r < 80) return $urandom_range(7, 10);
            if (r < 95) return $urandom_range(1, 6);
            return $urandom_range(11, MAX_LEN);
        end
        if (r < 85) return $urandom_range(1, 8);
        return $urandom_range(9, MAX_LEN);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic [31:0] t);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.rx_byte <= b;
        req_if.time_ms <= t;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // length byte is sent as given; a bad length is followed by a few stray bytes
    task automatic send_frame(input logic [7:0] ftype, input int len, input t_flaw flaw,
                              input logic [55:0] head, input bit use_head,
                              input logic [31:0] lf_time, input bit pin_time);
        logic [7:0] frame_q [$];
        logic [7:0] pb;
        logic [7:0] chk;
        int         n_payload;
        int         keep;
        int         i;
        frame_q.push_back(fstp_pkg::SYNC1_BYTE);
        if (flaw == FLAW_SYNC2) frame_q.push_back(fstp_pkg::SYNC1_BYTE);
        frame_q.push_back(fstp_pkg::SYNC2_BYTE);
        frame_q.push_back(8'(len));
        frame_q.push_back(ftype);
        chk = 8'(len) ^ ftype;
        n_payload = (flaw == FLAW_LEN) ? 3 : len;
        for (i = 0; i < n_payload; i++) begin
            case ($urandom_range(0, 7))
                0:       pb = fstp_pkg::SYNC1_BYTE;
                1:       pb = fstp_pkg::SYNC2_BYTE;
                2:       pb = fstp_pkg::CR_BYTE;
                3:       pb = fstp_pkg::LF_BYTE;
                default: pb = 8'($urandom);
            endcase
            if (use_head && i < fstp_pkg::HEAD_DEPTH) pb = head[8*i +: 8];
            chk = chk ^ pb;
            frame_q.push_back(pb);
        end
        frame_q.push_back((flaw == FLAW_CHK) ? chk ^ 8'($urandom_range(1, 255)) : chk);
        frame_q.push_back((flaw == FLAW_CR) ? fstp_pkg::CR_BYTE ^ 8'($urandom_range(1, 255))
                                            : fstp_pkg::CR_BYTE);
        frame_q.push_back((flaw == FLAW_LF) ? fstp_pkg::LF_BYTE ^ 8'($urandom_range(1, 255))
                                            : fstp_pkg::LF_BYTE);
        if (flaw == FLAW_CUT) begin
            keep = $urandom_range(1, frame_q.size() - 2);
            frame_q = frame_q[0:keep-1];
        end
        foreach (frame_q[k]) begin
            send_byte(frame_q[k], (pin_time && k == frame_q.size() - 1) ? lf_time : next_ms());
        end
        frames_sent++;
    endtask

    // drain the result channel before switching flow-control profile
    task automatic set_profile(input int snd_pct, input int rcv_pct);
        req_if.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
    endtask

    initial begin
        int          r;
        int          stage;
        logic [7:0]  ftype;
        t_flaw       flaw;
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.rx_byte = '0;
        req_if.time_ms = '0;
        snd_idle_pct   = 8;
        rcv_idle_pct   = 87;
        ms_now         = $urandom();
        stage          = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_profile(8, 87);

        // directed: field extremes, all frame types, every error path
        send_frame(fstp_pkg::TYPE_TARGET, 7, FLAW_NONE, '0, 1, 32'h0000_0000, 1);
        send_frame(fstp_pkg::TYPE_TARGET, 7, FLAW_NONE,
                   {16'hFFFF, 8'hFF, 16'h8000, 16'h7FFF}, 1, 32'hFFFF_FFFF, 1);
        send_frame(fstp_pkg::TYPE_TARGET, 7, FLAW_NONE,
                   {16'h0000, 8'h00, 16'h7FFF, 16'h8000}, 1, 32'h8000_0000, 1);
        send_frame(fstp_pkg::TYPE_TARGET, MAX_LEN, FLAW_NONE, '0, 0, '0, 0);
        send_frame(fstp_pkg::TYPE_TARGET, 6, FLAW_NONE, '0, 0, '0, 0);
        send_frame(fstp_pkg::TYPE_CMD, 1, FLAW_NONE, 56'h00, 1, '0, 0);
        send_frame(fstp_pkg::TYPE_CMD, 1, FLAW_NONE, 56'hFF, 1, '0, 0);
        send_frame(fstp_pkg::TYPE_CMD, MAX_LEN, FLAW_NONE, '0, 0, '0, 0);
        send_frame(8'h00, 3, FLAW_NONE, '0, 0, '0, 0);
        send_frame(8'hFF, 7, FLAW_NONE, '0, 0, '0, 0);
        send_frame(8'h03, 7, FLAW_NONE, '0, 0, '0, 0);
        send_frame(fstp_pkg::TYPE_TARGET, 0, FLAW_LEN, '0, 0, '0, 0);
        send_frame(fstp_pkg::TYPE_TARGET, MAX_LEN + 1, FLAW_LEN, '0, 0, '0, 0);
        send_frame(fstp_pkg::TYPE_CMD, 255, FLAW_LEN, '0, 0, '0, 0);
        send_frame(fstp_pkg::TYPE_TARGET, 7, FLAW_SYNC2, '0, 0, '0, 0);
        send_frame(fstp_pkg::TYPE_TARGET, 7, FLAW_CHK, '0, 0, '0, 0);
        send_frame(fstp_pkg::TYPE_TARGET, 7, FLAW_CR, '0, 0, '0, 0);
        send_frame(fstp_pkg::TYPE_CMD, 2, FLAW_LF, '0, 0, '0, 0);
        send_byte(8'h00, next_ms());
        send_byte(8'hFF, next_ms());
        send_frame(fstp_pkg::TYPE_TARGET, 9, FLAW_CUT, '0, 0, '0, 0);
        send_frame(fstp_pkg::TYPE_TARGET, 8, FLAW_NONE, '0, 0, '0, 0);
        send_frame(fstp_pkg::TYPE_CMD, 3, FLAW_NONE, '0, 0, '0, 0);

        while (bytes_sent < N_ITEMS) begin
            if (stage < 2 && bytes_sent >= (stage + 1) * N_ITEMS / 3) begin
                stage++;
                if (stage == 1) set_profile(87, 8);
                else set_profile(0, 0);
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
                r = $urandom_range(0, 99);
                if (r < 45) ftype = fstp_pkg::TYPE_TARGET;
                else if (r < 80) ftype = fstp_pkg::TYPE_CMD;
                else ftype = 8'($urandom);
                send_frame(ftype, pick_len(ftype), FLAW_NONE, '0, 0, '0, 0);
            end else if (r < 88) begin
                flaw  = t_flaw'($urandom_range(FLAW_SYNC2, FLAW_CUT));
                ftype = $urandom_range(0, 1) ? fstp_pkg::TYPE_TARGET : fstp_pkg::TYPE_CMD;
                if (flaw == FLAW_LEN) begin
                    send_frame(ftype,
                               ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(MAX_LEN + 1, 255),
                               flaw, '0, 0, '0, 0);
                end else begin
                    send_frame(ftype, pick_len(ftype), flaw, '0, 0, '0, 0);
                end
            end else begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom), next_ms());
            end
        end

        req_if.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);

        $display("Run covered %0d bytes in %0d frames and noise bursts over three stall profiles,",
                 bytes_sent, frames_sent);
        $display("with %0d target and %0d command frames decoded.", n_targets, n_commands);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
